/* design/msb_pkg.sv */
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the masked sprite blitter.
// ----------------------------------------------------------------------------
package msb_pkg;

    localparam int SCREEN_COLUMNS_DEF = 84;
    localparam int SCREEN_PAGES_DEF   = 6;

    // wide enough for the largest store (256 columns x 32 pages)
    localparam int ADDR_W = 13;

    localparam int CQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;

    localparam logic [1:0] KIND_BEGIN   = 2'd0;
    localparam logic [1:0] KIND_PAIR    = 2'd1;
    localparam logic [1:0] KIND_HOST_WR = 2'd2;
    localparam logic [1:0] KIND_HOST_RD = 2'd3;

    typedef enum logic [1:0] {
        OP_BLIT    = 2'd0,
        OP_HOST_WR = 2'd1,
        OP_HOST_RD = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [7:0] x_pos;
        logic signed [7:0] y_pos;
        logic [7:0]        sprite_width;
        logic [7:0]        sprite_height;
        logic              grey_as_white;
        logic [7:0]        layer_one;
        logic [7:0]        layer_two;
        logic [8:0]        store_address;
        logic [7:0]        store_data;
    } item_t;

    typedef struct packed {
        logic [8:0] out_address;
        logic [7:0] out_data;
        logic       is_read;
        logic       last;
    } result_t;

    // one store operation handed from the front to the back
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [8:0]        rep_addr;
        logic [7:0]        clr_mask;
        logic [7:0]        set_mask;
        logic              last;
        logic              oor;
    } cmd_t;

endpackage

/* design/msb_ram.sv */
// ----------------------------------------------------------------------------
// msb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/msb_fifo.sv */
// ----------------------------------------------------------------------------
// msb_fifo
// Small register FIFO; the head entry is shown while not empty.
// ----------------------------------------------------------------------------
module msb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/msb_front.sv */
// ----------------------------------------------------------------------------
// msb_front
// Item decode: sprite state, mask build, shift, carry and clipping.
// Emits store operations toward the back end.
// ----------------------------------------------------------------------------
module msb_front #(
    parameter int SCREEN_COLUMNS = 84,
    parameter int SCREEN_PAGES   = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  msb_pkg::item_t item,
    input  logic           clearing,
    input  logic           cq_full,
    output logic           cq_push,
    output msb_pkg::cmd_t  cq_data
);

    import msb_pkg::*;

    localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_PAGES;

    logic [7:0]  origin_x_reg;
    logic [5:0]  origin_page_reg;
    logic [2:0]  bit_shift_reg;
    logic [7:0]  width_left_reg;
    logic [5:0]  rows_reg;
    logic [5:0]  row_reg;
    logic [7:0]  col_reg;
    logic [7:0]  carry_clr_reg;
    logic [7:0]  carry_set_reg;
    logic        extra_reg;
    logic        grey_hidden_reg;
    logic        pend_valid_reg;
    cmd_t        pend_reg;

    logic        accept;
    logic [5:0]  y_page;
    logic [5:0]  h_rows;
    logic [9:0]  span_rows;
    logic [7:0]  grey_keep;
    logic [7:0]  draw_mask;
    logic [7:0]  or_mask;
    logic [15:0] sh_and;
    logic [15:0] sh_or;
    logic [7:0]  page_s;
    logic [7:0]  page2_s;
    logic [9:0]  col_s;
    logic        col_ok;
    logic        page_ok;
    logic        page2_ok;
    logic        pair_live;
    logic        last_row;
    logic        a_valid;
    logic        b_valid;
    logic        host_ok;
    logic [ADDR_W-1:0] idx_a;
    logic [ADDR_W-1:0] idx_b;
    logic [ADDR_W-1:0] host_addr;
    cmd_t        cmd_a;
    cmd_t        cmd_b;
    cmd_t        cmd_host;
    logic        pend_load;

    assign full   = clearing || cq_full || pend_valid_reg;
    assign accept = push && !full;

    // begin item: floor(y / 8) and the page span of the shifted sprite
    assign y_page    = {item.y_pos[7], item.y_pos[7:3]};
    assign h_rows    = 6'(({1'b0, item.sprite_height} + 9'd7) >> 3);
    assign span_rows = ({7'd0, item.y_pos[2:0]} + {2'b00, item.sprite_height} + 10'd7) >> 3;

    // layer pair to masks
    assign grey_keep = grey_hidden_reg ? 8'h00 : 8'hFF;
    assign draw_mask = item.layer_one | item.layer_two;
    assign or_mask   = item.layer_one & (~item.layer_two | (item.layer_two & grey_keep));
    assign sh_and    = {8'h00, draw_mask} << bit_shift_reg;
    assign sh_or     = {8'h00, or_mask} << bit_shift_reg;

    // destination, signed page and column
    assign page_s  = {{2{origin_page_reg[5]}}, origin_page_reg} + {2'b00, row_reg};
    assign page2_s = page_s + 8'd1;
    assign col_s   = {{2{origin_x_reg[7]}}, origin_x_reg} + {2'b00, col_reg};

    assign col_ok   = !col_s[9] && (col_s[8:0] < 9'(SCREEN_COLUMNS));
    assign page_ok  = !page_s[7] && (page_s[6:0] < 7'(SCREEN_PAGES));
    assign page2_ok = !page2_s[7] && (page2_s[6:0] < 7'(SCREEN_PAGES));

    assign idx_a = ADDR_W'(page_s[4:0]) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_s[7:0]);
    assign idx_b = ADDR_W'(page2_s[4:0]) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_s[7:0]);

    assign pair_live = (width_left_reg != 8'd0) && (rows_reg != 6'd0);
    assign last_row  = ({1'b0, row_reg} + 7'd1) >= {1'b0, rows_reg};
    assign a_valid   = pair_live && col_ok && page_ok;
    assign b_valid   = pair_live && last_row && extra_reg && col_ok && page2_ok;

    assign host_addr = ADDR_W'(item.store_address);
    assign host_ok   = host_addr < ADDR_W'(STORE_SIZE);

    always_comb
    begin
        cmd_a          = '0;
        cmd_a.op       = OP_BLIT;
        cmd_a.addr     = idx_a;
        cmd_a.rep_addr = idx_a[8:0];
        cmd_a.clr_mask = sh_and[7:0] | carry_clr_reg;
        cmd_a.set_mask = sh_or[7:0] | carry_set_reg;
        cmd_a.last     = !b_valid;

        cmd_b          = '0;
        cmd_b.op       = OP_BLIT;
        cmd_b.addr     = idx_b;
        cmd_b.rep_addr = idx_b[8:0];
        cmd_b.clr_mask = sh_and[15:8];
        cmd_b.set_mask = sh_or[15:8];
        cmd_b.last     = 1'b1;

        cmd_host          = '0;
        cmd_host.op       = (item.kind == KIND_HOST_WR) ? OP_HOST_WR : OP_HOST_RD;
        cmd_host.addr     = host_ok ? host_addr : '0;
        cmd_host.rep_addr = item.store_address;
        cmd_host.set_mask = item.store_data;
        cmd_host.last     = 1'b1;
        cmd_host.oor      = !host_ok;
    end

    always_comb
    begin
        cq_push   = 1'b0;
        cq_data   = pend_reg;
        pend_load = 1'b0;
        if (pend_valid_reg)
        begin
            cq_push = !cq_full;
        end
        else if (accept)
        begin
            unique case (item.kind)
                KIND_PAIR:
                begin
                    if (a_valid)
                    begin
                        cq_push   = 1'b1;
                        cq_data   = cmd_a;
                        pend_load = b_valid;
                    end
                    else if (b_valid)
                    begin
                        cq_push = 1'b1;
                        cq_data = cmd_b;
                    end
                end
                KIND_HOST_WR:
                begin
                    cq_push = host_ok;
                    cq_data = cmd_host;
                end
                KIND_HOST_RD:
                begin
                    cq_push = 1'b1;
                    cq_data = cmd_host;
                end
                default:
                begin
                    cq_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            pend_reg <= cmd_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_page_reg <= '0;
            bit_shift_reg   <= '0;
            width_left_reg  <= '0;
            rows_reg        <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            carry_clr_reg   <= '0;
            carry_set_reg   <= '0;
            extra_reg       <= 1'b0;
            grey_hidden_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pend_valid_reg && !cq_full)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end

            if (accept && (item.kind == KIND_BEGIN))
            begin
                origin_x_reg    <= item.x_pos;
                origin_page_reg <= y_page;
                bit_shift_reg   <= item.y_pos[2:0];
                width_left_reg  <= item.sprite_width;
                rows_reg        <= h_rows;
                extra_reg       <= span_rows > {4'd0, h_rows};
                grey_hidden_reg <= item.grey_as_white;
                row_reg         <= '0;
                col_reg         <= '0;
                carry_clr_reg   <= '0;
                carry_set_reg   <= '0;
            end
            else if (accept && (item.kind == KIND_PAIR) && pair_live)
            begin
                if (last_row)
                begin
                    row_reg        <= '0;
                    carry_clr_reg  <= '0;
                    carry_set_reg  <= '0;
                    col_reg        <= col_reg + 8'd1;
                    width_left_reg <= width_left_reg - 8'd1;
                end
                else
                begin
                    row_reg       <= row_reg + 6'd1;
                    carry_clr_reg <= sh_and[15:8];
                    carry_set_reg <= sh_or[15:8];
                end
            end
        end
    end

endmodule

/* design/msb_back.sv */
// ----------------------------------------------------------------------------
// msb_back
// Store engine: clear sweep, read-modify-write pipeline, result queue.
// ----------------------------------------------------------------------------
module msb_back #(
    parameter int SCREEN_COLUMNS = 84,
    parameter int SCREEN_PAGES   = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cq_empty,
    input  msb_pkg::cmd_t    cq_head,
    output logic             cq_pop,
    output logic             clearing,
    input  logic             pop,
    output logic             empty,
    output msb_pkg::result_t result
);

    import msb_pkg::*;

    localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int OCW        = $clog2(OQ_DEPTH + 1);

    logic          clearing_reg;
    logic [AW-1:0] clear_cnt_reg;
    logic          b_valid_reg;
    cmd_t          b_cmd_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;

    logic          issue;
    logic [OCW:0]  in_flight;
    logic [OCW-1:0] oq_count;
    logic          oq_full;
    logic [7:0]    rdata;
    logic [7:0]    old_byte;
    logic [7:0]    new_byte;
    logic          b_we;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          res_push;
    result_t       res_data;
    logic [$bits(result_t)-1:0] oq_head;

    assign clearing  = clearing_reg;
    assign in_flight = {1'b0, oq_count} + {{OCW{1'b0}}, b_valid_reg};
    assign issue     = !clearing_reg && !cq_empty && (in_flight < (OCW + 1)'(OQ_DEPTH));
    assign cq_pop    = issue;

    // latest write is forwarded: the RAM returns the old byte on a same-cycle hit
    assign old_byte = (fwd_valid_reg && (fwd_addr_reg == b_cmd_reg.addr[AW-1:0]))
                      ? fwd_data_reg : rdata;

    always_comb
    begin
        b_we     = 1'b0;
        new_byte = (old_byte & ~b_cmd_reg.clr_mask) | b_cmd_reg.set_mask;
        res_push = 1'b0;
        res_data = '0;
        res_data.out_address = b_cmd_reg.rep_addr;
        if (b_valid_reg)
        begin
            unique case (b_cmd_reg.op)
                OP_BLIT:
                begin
                    b_we              = 1'b1;
                    res_push          = 1'b1;
                    res_data.out_data = new_byte;
                    res_data.last     = b_cmd_reg.last;
                end
                OP_HOST_WR:
                begin
                    b_we     = 1'b1;
                    new_byte = b_cmd_reg.set_mask;
                end
                OP_HOST_RD:
                begin
                    res_push          = 1'b1;
                    res_data.out_data = b_cmd_reg.oor ? 8'h00 : old_byte;
                    res_data.is_read  = 1'b1;
                    res_data.last     = 1'b1;
                end
                default:
                begin
                    b_we = 1'b0;
                end
            endcase
        end
    end

    assign ram_we    = clearing_reg || b_we;
    assign ram_waddr = clearing_reg ? clear_cnt_reg : b_cmd_reg.addr[AW-1:0];
    assign ram_wdata = clearing_reg ? 8'h00 : new_byte;

    msb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cq_head.addr[AW-1:0]),
        .rdata (rdata)
    );

    msb_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OQ_DEPTH)
    ) u_oq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (pop),
        .head      (oq_head),
        .full      (oq_full),
        .empty     (empty),
        .count     (oq_count)
    );

    assign result = result_t'(oq_head);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_cmd_reg <= cq_head;
        end
        if (b_we)
        begin
            fwd_addr_reg <= b_cmd_reg.addr[AW-1:0];
            fwd_data_reg <= new_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clear_cnt_reg == AW'(STORE_SIZE - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clear_cnt_reg <= clear_cnt_reg + 1'b1;
                end
            end
            // credit check keeps the result queue from overflowing
            b_valid_reg <= issue && !oq_full;
            if (b_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

endmodule

/* design/masked_sprite_blit_paged_display.sv */
// ----------------------------------------------------------------------------
// masked_sprite_blit_paged_display
// Masked sprite blitter over a page-organized monochrome frame store.
// ----------------------------------------------------------------------------
// Items enter through a queue port (push/full) and results leave through one
// (empty/pop). Begin items, host writes and layer pairs that touch at most one
// store byte are taken at one per cycle while the command queue has room; a
// pair that also spills into the page below puts two operations in the command
// queue and holds full until the second has entered it. The back end performs
// one store read-modify-write per cycle, while the result queue has room,
// through the single write port of the frame store. After reset all
// SCREEN_COLUMNS * SCREEN_PAGES store bytes (504 at the default size) are
// swept to zero, one byte per cycle, and full stays high until the sweep ends.
// ----------------------------------------------------------------------------
module masked_sprite_blit_paged_display #(
    parameter int SCREEN_COLUMNS = msb_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_PAGES   = msb_pkg::SCREEN_PAGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  msb_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output msb_pkg::result_t result
);

    import msb_pkg::*;

    logic clearing;
    logic cq_full;
    logic cq_push;
    cmd_t cq_data;
    logic cq_empty;
    logic cq_pop;
    logic [$bits(cmd_t)-1:0] cq_head_bits;
    logic [$clog2(CQ_DEPTH+1)-1:0] cq_count;

    msb_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .clearing (clearing),
        .cq_full  (cq_full),
        .cq_push  (cq_push),
        .cq_data  (cq_data)
    );

    msb_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CQ_DEPTH)
    ) u_cq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cq_push),
        .push_data (cq_data),
        .pop       (cq_pop),
        .head      (cq_head_bits),
        .full      (cq_full),
        .empty     (cq_empty),
        .count     (cq_count)
    );

    msb_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_empty (cq_empty),
        .cq_head  (cmd_t'(cq_head_bits)),
        .cq_pop   (cq_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

/* design/msb_checker.sv */
// ----------------------------------------------------------------------------
// msb_checker
// Port-level checks on the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module msb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input msb_pkg::result_t result
);

    import msb_pkg::*;

    // store sweep blocks input right out of reset
    a_full_after_reset : assert property (@(posedge clk)
        $rose(rst_n) |-> full && empty)
        else $error("input open or result shown right after reset");

    a_head_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before pop");

    a_read_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_read) |-> result.last)
        else $error("host read reply without last");

    // a host read reply is alone for its item, so the result before it ended its item
    a_read_follows_last : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=> (empty || !result.is_read))
        else $error("host read reply inside a blit item");

endmodule

bind masked_sprite_blit_paged_display msb_checker u_msb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
